/* rtl/mpvt_pkg.sv */
//------------------------------------------------------------------------------
// mpvt_pkg
// Types, register indexes and command codes shared by the view transform.
//------------------------------------------------------------------------------
package mpvt_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MAP_CENTER    = 3'd0;
  localparam logic [2:0] REG_MODE_SHIFT    = 3'd1;
  localparam logic [2:0] REG_ROT_ROW_X     = 3'd2;
  localparam logic [2:0] REG_ROT_ROW_Y     = 3'd3;
  localparam logic [2:0] REG_ROT_ROW_Z     = 3'd4;
  localparam logic [2:0] REG_DEPTH_PARAMS  = 3'd5;
  localparam logic [2:0] REG_SCREEN_OFFSET = 3'd6;
  localparam logic [2:0] REG_PROJ_SCALES   = 3'd7;

  // clip history visibility codes
  localparam logic [1:0] VIS_NO      = 2'd0;
  localparam logic [1:0] VIS_YES     = 2'd1;
  localparam logic [1:0] VIS_UNKNOWN = 2'd2;

  // datapath operation codes
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;  // point minus center, then shift
  localparam logic [3:0] OP_MUL_A  = 4'd2;  // products of the dx terms
  localparam logic [3:0] OP_MUL_B  = 4'd3;  // sum with dy terms, z offset
  localparam logic [3:0] OP_CLIPM  = 4'd4;  // clip numerators
  localparam logic [3:0] OP_CLIPDX = 4'd5;  // start x intersection divide
  localparam logic [3:0] OP_CLIPDY = 4'd6;  // start y intersection divide
  localparam logic [3:0] OP_SELI   = 4'd7;  // select intersection to emit
  localparam logic [3:0] OP_SELP   = 4'd8;  // select the point to emit
  localparam logic [3:0] OP_PMUL   = 4'd9;  // perspective numerators
  localparam logic [3:0] OP_PDX    = 4'd10;
  localparam logic [3:0] OP_PDY    = 4'd11;
  localparam logic [3:0] OP_PDW    = 4'd12;
  localparam logic [3:0] OP_FIN    = 4'd13; // offset and cull distance
  localparam logic [3:0] OP_HIST   = 4'd14; // update clip history

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               first_point;
    logic               last_point;
    logic               next_is_start;
    logic [15:0]        min_distance;
    logic [15:0]        line_width;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] drawn_width;
    logic               last_of_run;
  } out_item_t;

  // command from controller to datapath
  typedef struct packed {
    logic [3:0] op;
    logic       hist_int;  // history takes the intersection
    logic       commit;    // record emitted point as last output
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_busy;
    logic changed;   // visibility changed against history
    logic vis;       // current point visible
    logic den_zero;  // clip divisor is zero
    logic ddd;       // 3d mode
    logic culled;    // result falls inside min distance
  } dp_sts_t;

endpackage

/* rtl/mpvt_div.sv */
//------------------------------------------------------------------------------
// mpvt_div
// Radix-2 signed divider, 64-bit dividend by 32-bit divisor, truncating.
//------------------------------------------------------------------------------
module mpvt_div import mpvt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               busy,
  output logic [63:0]        quotient
);

  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;
  logic [33:0] diff;

  // one quotient bit per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[31:0], q_r[63]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    if (start) begin
      q_nxt    = dividend[63] ? 64'(-dividend) : dividend;
      dvs_nxt  = divisor[31] ? 32'(-divisor) : divisor;
      neg_nxt  = dividend[63] ^ divisor[31];
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? 64'(-q_r) : q_r;

endmodule

/* rtl/mpvt_datapath.sv */
//------------------------------------------------------------------------------
// mpvt_datapath
// Configuration registers, transform arithmetic, clip history and divider.
//------------------------------------------------------------------------------
module mpvt_datapath import mpvt_pkg::*; #(
  parameter int FRACTION_SHIFT = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic       ld_in,
  input  in_item_t   in_item,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output out_item_t  res
);

  // configuration
  logic [63:0] center_r, rotx_r, roty_r, rotz_r, depth_r, soff_r;
  logic [5:0]  mode_r;
  logic [62:0] scales_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0; mode_r <= '0; rotx_r <= '0; roty_r <= '0;
      rotz_r <= '0; depth_r <= '0; soff_r <= '0; scales_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAP_CENTER:    center_r <= cfg_data;
        REG_MODE_SHIFT:    mode_r   <= cfg_data[5:0];
        REG_ROT_ROW_X:     rotx_r   <= cfg_data;
        REG_ROT_ROW_Y:     roty_r   <= cfg_data;
        REG_ROT_ROW_Z:     rotz_r   <= cfg_data;
        REG_DEPTH_PARAMS:  depth_r  <= cfg_data;
        REG_SCREEN_OFFSET: soff_r   <= cfg_data;
        REG_PROJ_SCALES:   scales_r <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  logic ddd;
  logic signed [31:0] zl;
  assign ddd = mode_r[5];
  assign zl  = depth_r[31:0];

  // working registers
  in_item_t           it_r;
  logic signed [31:0] dx_r, dy_r, rx_r, ry_r, rz_r;
  logic [31:0]        ax_r, ay_r, az_r;
  logic signed [63:0] nx_r, ny_r;
  logic signed [31:0] ex_r, ey_r, ez_r, ix_r, iy_r;
  logic signed [63:0] pnx_r, pny_r, pnw_r;
  logic signed [31:0] qx_r, qy_r, qw_r;
  logic signed [31:0] ox_r, oy_r;
  logic [33:0]        dist_sum;
  logic [1:0]         pvis_r;
  logic signed [31:0] px_r, py_r, pz_r, lox_r, loy_r;
  logic [1:0]         qsel_r;

  logic signed [31:0] sx, sy, den, fnum, cdx, cdy;
  logic               vis_c;
  assign sx    = it_r.coord_x - center_r[63:32];
  assign sy    = it_r.coord_y - center_r[31:0];
  assign vis_c = rz_r >= zl;
  assign den   = pz_r - rz_r;
  assign fnum  = zl - rz_r;
  // history to point differences, wrapped at 32 bits
  assign cdx   = px_r - rx_r;
  assign cdy   = py_r - ry_r;

  // divider sharing
  logic               div_start, div_busy, div_busy_d;
  logic signed [63:0] div_a;
  logic signed [31:0] div_b;
  logic [63:0]        div_q;
  always_comb begin
    div_start = 1'b0;
    div_a     = nx_r;
    div_b     = den;
    case (cmd.op)
      OP_CLIPDX: begin div_start = 1'b1; div_a = nx_r;  div_b = den; end
      OP_CLIPDY: begin div_start = 1'b1; div_a = ny_r;  div_b = den; end
      OP_PDX:    begin div_start = 1'b1; div_a = pnx_r; div_b = ez_r; end
      OP_PDY:    begin div_start = 1'b1; div_a = pny_r; div_b = ez_r; end
      OP_PDW:    begin div_start = 1'b1; div_a = pnw_r; div_b = ez_r; end
      default: ;
    endcase
  end

  mpvt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  // capture quotient when the divider finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_d <= 1'b0;
    end else begin
      div_busy_d <= div_busy;
    end
    if (div_start) begin
      qsel_r <= (cmd.op == OP_CLIPDX || cmd.op == OP_PDX) ? 2'd0 :
                (cmd.op == OP_CLIPDY || cmd.op == OP_PDY) ? 2'd1 : 2'd2;
    end
    if (div_busy_d && !div_busy) begin
      case (qsel_r)
        2'd0:    qx_r <= div_q[31:0];
        2'd1:    qy_r <= div_q[31:0];
        default: qw_r <= div_q[31:0];
      endcase
    end
  end

  // point pipeline
  logic signed [31:0] e_x, e_y, fx, fy;
  logic [32:0] adx, ady;
  assign e_x = ex_r; assign e_y = ey_r;
  assign fx  = ddd ? ((ez_r == 0) ? 32'sd0 : qx_r) : (e_x >>> FRACTION_SHIFT);
  assign fy  = ddd ? ((ez_r == 0) ? 32'sd0 : qy_r) : (e_y >>> FRACTION_SHIFT);
  logic signed [32:0] ddx, ddy;
  assign ddx = 33'(ox_r) - 33'(lox_r);
  assign ddy = 33'(oy_r) - 33'(loy_r);
  assign adx = ddx[32] ? 33'(-ddx) : ddx;
  assign ady = ddy[32] ? 33'(-ddy) : ddy;

  always_ff @(posedge clk) begin
    if (ld_in) begin
      it_r <= in_item;
    end
    case (cmd.op)
      OP_LOAD: begin
        dx_r <= sx >>> mode_r[4:0];
        dy_r <= sy >>> mode_r[4:0];
      end
      OP_MUL_A: begin
        ax_r <= 32'(dx_r * rotx_r[63:32]);
        ay_r <= 32'(dx_r * roty_r[63:32]);
        az_r <= 32'(dx_r * rotz_r[63:32]);
      end
      OP_MUL_B: begin
        rx_r <= ax_r + 32'(dy_r * rotx_r[31:0]);
        ry_r <= ay_r + 32'(dy_r * roty_r[31:0]);
        rz_r <= az_r + 32'(dy_r * rotz_r[31:0])
                + 32'(depth_r[63:32] << FRACTION_SHIFT);
      end
      OP_CLIPM: begin
        nx_r <= 64'(cdx) * 64'(fnum);
        ny_r <= 64'(cdy) * 64'(fnum);
      end
      OP_SELI: begin
        ix_r <= (den == 0) ? rx_r : rx_r + qx_r;
        iy_r <= (den == 0) ? ry_r : ry_r + qy_r;
        ex_r <= (den == 0) ? rx_r : rx_r + qx_r;
        ey_r <= (den == 0) ? ry_r : ry_r + qy_r;
        ez_r <= zl;
      end
      OP_SELP: begin
        ex_r <= rx_r; ey_r <= ry_r; ez_r <= rz_r;
      end
      OP_PMUL: begin
        pnx_r <= 64'(ex_r) * $signed({43'd0, scales_r[62:42]});
        pny_r <= 64'(ey_r) * $signed({43'd0, scales_r[41:21]});
        pnw_r <= $signed({48'd0, it_r.line_width}) * $signed({43'd0, scales_r[20:0]});
      end
      OP_FIN: begin
        ox_r <= fx + soff_r[63:32];
        oy_r <= fy + soff_r[31:0];
      end
      default: ;
    endcase
  end

  assign dist_sum = {1'b0, adx} + {1'b0, ady};

  // clip history and last emitted point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvis_r <= VIS_UNKNOWN;
      px_r <= '0; py_r <= '0; pz_r <= '0;
      lox_r <= '0; loy_r <= '0;
    end else begin
      if (ld_in && in_item.first_point) begin
        pvis_r <= VIS_UNKNOWN;
      end
      if (cmd.op == OP_HIST) begin
        pvis_r <= vis_c ? VIS_YES : VIS_NO;
        if (cmd.hist_int) begin
          px_r <= ix_r; py_r <= iy_r; pz_r <= zl;
        end else begin
          px_r <= rx_r; py_r <= ry_r; pz_r <= rz_r;
        end
      end
      if (cmd.commit) begin
        lox_r <= ox_r; loy_r <= oy_r;
      end
    end
  end

  assign sts.div_busy = div_busy || div_start || (div_busy_d && !div_busy);
  assign sts.changed  = (pvis_r != VIS_UNKNOWN) && ((vis_c ? VIS_YES : VIS_NO) != pvis_r);
  assign sts.vis      = vis_c;
  assign sts.den_zero = (den == 0);
  assign sts.ddd      = ddd;
  assign sts.culled   = !it_r.first_point && !it_r.last_point && !it_r.next_is_start
                        && (it_r.min_distance != 16'd0)
                        && (dist_sum < {18'd0, it_r.min_distance});

  assign res.screen_x    = ox_r;
  assign res.screen_y    = oy_r;
  assign res.drawn_width = ddd ? ((ez_r == 0) ? 32'sd0 : qw_r)
                               : $signed({16'd0, it_r.line_width});
  assign res.last_of_run = 1'b0;

endmodule

/* rtl/mpvt_ctrl.sv */
//------------------------------------------------------------------------------
// mpvt_ctrl
// Sequencer for one point: transform, clip, project, cull and deliver.
//------------------------------------------------------------------------------
module mpvt_ctrl import mpvt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    ld_in,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    out_last,
  output logic    out_load,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_LOAD = 5'd1,  S_MA = 5'd2,  S_MB = 5'd3,
                         S_DEC  = 5'd4,  S_CM = 5'd5,    S_CDX = 5'd6, S_WX = 5'd7,
                         S_CDY  = 5'd8,  S_WY = 5'd9,    S_SELI = 5'd10, S_SELP = 5'd11,
                         S_PM   = 5'd12, S_PDX = 5'd13,  S_WPX = 5'd14, S_PDY = 5'd15,
                         S_WPY  = 5'd16, S_PDW = 5'd17,  S_WPW = 5'd18, S_FIN = 5'd19,
                         S_CULL = 5'd20, S_OUT = 5'd21,  S_NEXT = 5'd22, S_HIS = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic       two_r, two_nxt;     // second result (the point) still pending
  logic       pend_r, pend_nxt;   // intersection held until the point is decided
  logic       ovalid_r, ovalid_nxt;
  logic       olast_r, olast_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign ld_in     = in_valid && (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_last  = olast_r;

  always_comb begin
    state_nxt  = state_r;
    two_nxt    = two_r;
    pend_nxt   = pend_r;
    ovalid_nxt = ovalid_r;
    olast_nxt  = olast_r;
    cmd        = '{op: OP_NONE, hist_int: 1'b0, commit: 1'b0};
    out_load   = 1'b0;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: if (ld_in) begin
        state_nxt = S_LOAD; two_nxt = 1'b0; pend_nxt = 1'b0;
      end
      S_LOAD: begin cmd.op = OP_LOAD; state_nxt = S_MA; end
      S_MA:   begin cmd.op = OP_MUL_A; state_nxt = S_MB; end
      S_MB:   begin cmd.op = OP_MUL_B; state_nxt = S_DEC; end
      S_DEC: begin
        if (!sts.ddd) begin
          state_nxt = S_SELP;
        end else if (sts.changed) begin
          two_nxt   = sts.vis;
          state_nxt = sts.den_zero ? S_SELI : S_CM;
        end else begin
          cmd.op    = OP_HIST;
          state_nxt = sts.vis ? S_SELP : S_NEXT;
        end
      end
      S_CM:   begin cmd.op = OP_CLIPM; state_nxt = S_CDX; end
      S_CDX:  begin cmd.op = OP_CLIPDX; state_nxt = S_WX; end
      S_WX:   if (!sts.div_busy) state_nxt = S_CDY;
      S_CDY:  begin cmd.op = OP_CLIPDY; state_nxt = S_WY; end
      S_WY:   if (!sts.div_busy) state_nxt = S_SELI;
      S_SELI: begin cmd.op = OP_SELI; state_nxt = S_HIS; end
      // history keeps the point when it is visible, else the intersection
      S_HIS: begin
        cmd.op       = OP_HIST;
        cmd.hist_int = !two_r;
        state_nxt    = S_PM;
      end
      S_SELP: begin cmd.op = OP_SELP; state_nxt = sts.ddd ? S_PM : S_FIN; end
      S_PM:   begin cmd.op = OP_PMUL; state_nxt = S_PDX; end
      S_PDX:  begin cmd.op = OP_PDX; state_nxt = S_WPX; end
      S_WPX:  if (!sts.div_busy) state_nxt = S_PDY;
      S_PDY:  begin cmd.op = OP_PDY; state_nxt = S_WPY; end
      S_WPY:  if (!sts.div_busy) state_nxt = S_PDW;
      S_PDW:  begin cmd.op = OP_PDW; state_nxt = S_WPW; end
      S_WPW:  if (!sts.div_busy) state_nxt = S_FIN;
      S_FIN:  begin cmd.op = OP_FIN; state_nxt = S_CULL; end
      S_CULL: begin
        // a held intersection is released once the point's fate is known
        if (pend_r) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = sts.culled;
          pend_nxt   = 1'b0;
        end
        if (sts.culled) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (!ovalid_r || !out_stall) begin
        // results of one item leave in order
        out_load   = 1'b1;
        cmd.commit = 1'b1;
        if (two_r) begin
          pend_nxt   = 1'b1;
        end else begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b1;
        end
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (two_r) begin
          // point follows its intersection
          two_nxt   = 1'b0;
          state_nxt = S_SELP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      two_r    <= 1'b0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
      olast_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      two_r    <= two_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
      olast_r  <= olast_nxt;
    end
  end

endmodule

/* rtl/map_point_view_transform.sv */
//------------------------------------------------------------------------------
// map_point_view_transform
// Map polyline point to screen point transform with near-plane clipping.
//------------------------------------------------------------------------------
// Usage:
//   Points enter on the in_ channel (in_valid / in_stall); each gives zero,
//   one or two results on the out_ channel (out_valid / out_stall), the last
//   one flagged by last_of_run. Registers are written through cfg_valid /
//   cfg_ready / cfg_index / cfg_data while no point is in flight.
//   One point is processed at a time; the next point is taken once the
//   sequencer is idle again. A 3D point is set by the shared 64-step
//   radix-2 divider, one divide each for x, y and width. A clip adds two
//   divides per intersection: a point that leaves the view gives only the
//   intersection, one that returns gives two results, the intersection
//   being held until the point's culling is known.
//   Results sit in an output register; a stalled result holds its value
//   and the sequencer waits before loading the next one.
//   Synchronous reset clears the registers, the clip history (unknown
//   visibility) and the last emitted point (origin).
//------------------------------------------------------------------------------
module map_point_view_transform import mpvt_pkg::*; #(
  parameter int FRACTION_SHIFT = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t res;
  out_item_t out_r;
  logic      ld_in, out_load, out_last;

  assign cfg_ready = 1'b1;

  mpvt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .ld_in(ld_in), .out_stall(out_stall), .out_valid(out_valid),
    .out_last(out_last), .out_load(out_load), .cmd(cmd), .sts(sts)
  );

  mpvt_datapath #(.FRACTION_SHIFT(FRACTION_SHIFT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid && cfg_ready),
    .cfg_idx(cfg_index), .cfg_data(cfg_data), .ld_in(ld_in),
    .in_item(in_data), .cmd(cmd), .sts(sts), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  always_comb begin
    out_data             = out_r;
    out_data.last_of_run = out_last;
  end

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !out_load) else $error("result overwritten");

  // no item taken while a result is being loaded
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> in_stall) else $error("load while idle");

  // no result load in the cycle after a transfer in
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    ld_in |=> !out_load) else $error("load right after accept");

endmodule

/* tb/tb_map_point_view_transform.sv */
//------------------------------------------------------------------------------
// tb_map_point_view_transform
// Self-checking bench for the map point view transform: points are pushed
// through the input channel under random gaps, a cycle-free model predicts
// the screen points of each one, and every result transfer is compared field
// by field with the oldest prediction. Runs several register settings in 2D
// and 3D mode, including near-plane crossings and culling.
//------------------------------------------------------------------------------
module tb_map_point_view_transform;
  import mpvt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // register shadow and transform history
  logic [63:0] r_center, r_rot_x, r_rot_y, r_rot_z, r_depth, r_offset;
  logic [5:0]  r_mode;
  logic [62:0] r_scales;
  logic [1:0]  hist_vis;
  logic [31:0] hist_x, hist_y, hist_z, shown_x, shown_y;

  in_item_t  point_queue[$];
  out_item_t screen_queue[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        quiet_cycles = 0;
  bit        any_error = 1'b0;
  bit        in_taken = 1'b0;

  map_point_view_transform u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] sra32(logic [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  // project, offset and cull one screen point
  function automatic void project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        bit ddd, bit cull_ok, logic [15:0] mind,
                                        logic [15:0] width);
    longint zs, xq, yq, span;
    logic [31:0] w;
    out_item_t res;
    if (ddd) begin
      zs = longint'($signed(z));
      if (zs == 0) begin
        x = '0; y = '0; w = '0;
      end else begin
        xq = longint'($signed(x)) * longint'(r_scales[62:42]) / zs;
        yq = longint'($signed(y)) * longint'(r_scales[41:21]) / zs;
        x = xq[31:0];
        y = yq[31:0];
        xq = longint'(width) * longint'(r_scales[20:0]) / zs;
        w = xq[31:0];
      end
    end else begin
      w = {16'b0, width};
    end
    x = x + r_offset[63:32];
    y = y + r_offset[31:0];
    if (cull_ok && mind != 0) begin
      xq = longint'($signed(x)) - longint'($signed(shown_x));
      yq = longint'($signed(y)) - longint'($signed(shown_y));
      span = (xq < 0 ? -xq : xq) + (yq < 0 ? -yq : yq);
      if (span < longint'(mind)) return;
    end
    res.screen_x = x;
    res.screen_y = y;
    res.drawn_width = w;
    res.last_of_run = 1'b0;
    screen_queue.push_back(res);
    shown_x = x;
    shown_y = y;
  endfunction

  // predict the screen points of one accepted map point
  function automatic void predict_point(in_item_t p);
    logic [31:0] dx, dy, rx, ry, rz, zl, ix, iy;
    logic [1:0]  vis;
    longint      den, f, q;
    bit          ddd, cull_ok;
    int          before_n;
    ddd = r_mode[5];
    cull_ok = !p.first_point && !p.last_point && !p.next_is_start;
    before_n = screen_queue.size();
    if (p.first_point) hist_vis = VIS_UNKNOWN;
    dx = sra32(p.coord_x - r_center[63:32], r_mode[4:0]);
    dy = sra32(p.coord_y - r_center[31:0], r_mode[4:0]);
    rx = dx * r_rot_x[63:32] + dy * r_rot_x[31:0];
    ry = dx * r_rot_y[63:32] + dy * r_rot_y[31:0];
    rz = dx * r_rot_z[63:32] + dy * r_rot_z[31:0] + (r_depth[63:32] << 5);
    if (ddd) begin
      zl = r_depth[31:0];
      vis = ($signed(rz) >= $signed(zl)) ? VIS_YES : VIS_NO;
      if (hist_vis != VIS_UNKNOWN && vis != hist_vis) begin
        den = longint'($signed(hist_z - rz));
        ix = rx;
        iy = ry;
        if (den != 0) begin
          f = longint'($signed(zl - rz));
          q = longint'($signed(hist_x - rx)) * f / den;
          ix = rx + q[31:0];
          q = longint'($signed(hist_y - ry)) * f / den;
          iy = ry + q[31:0];
        end
        hist_x = ix; hist_y = iy; hist_z = zl; hist_vis = vis;
        project_point(ix, iy, zl, 1'b1, cull_ok, p.min_distance, p.line_width);
        if (vis == VIS_YES) begin
          hist_x = rx; hist_y = ry; hist_z = rz;
          project_point(rx, ry, rz, 1'b1, cull_ok, p.min_distance, p.line_width);
        end
      end else begin
        hist_x = rx; hist_y = ry; hist_z = rz; hist_vis = vis;
        if (vis == VIS_YES)
          project_point(rx, ry, rz, 1'b1, cull_ok, p.min_distance, p.line_width);
      end
    end else begin
      project_point(sra32(rx, 5), sra32(ry, 5), '0, 1'b0, cull_ok,
                    p.min_distance, p.line_width);
    end
    if (screen_queue.size() > before_n)
      screen_queue[screen_queue.size() - 1].last_of_run = 1'b1;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= point_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        predict_point(in_data);
      end
      if (out_valid && !out_stall) begin
        if (screen_queue.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", out_data.screen_x, out_data.screen_y);
          any_error = 1'b1;
        end else begin
          want = screen_queue.pop_front();
          if (out_data.screen_x !== want.screen_x) begin
            $error("screen_x expected %0d got %0d", want.screen_x, out_data.screen_x);
            any_error = 1'b1;
          end
          if (out_data.screen_y !== want.screen_y) begin
            $error("screen_y expected %0d got %0d", want.screen_y, out_data.screen_y);
            any_error = 1'b1;
          end
          if (out_data.drawn_width !== want.drawn_width) begin
            $error("drawn_width expected %0d got %0d", want.drawn_width,
                   out_data.drawn_width);
            any_error = 1'b1;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0b got %0b", want.last_of_run,
                   out_data.last_of_run);
            any_error = 1'b1;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAP_CENTER:    r_center = val;
      REG_MODE_SHIFT:    r_mode = val[5:0];
      REG_ROT_ROW_X:     r_rot_x = val;
      REG_ROT_ROW_Y:     r_rot_y = val;
      REG_ROT_ROW_Z:     r_rot_z = val;
      REG_DEPTH_PARAMS:  r_depth = val;
      REG_SCREEN_OFFSET: r_offset = val;
      default:           r_scales = val[62:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued point is taken and every result has arrived
  task automatic drain();
    while (point_queue.size() > 0 || in_valid || in_stall || screen_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_point(logic [31:0] x, logic [31:0] y, bit first,
                                          bit last, bit nstart, logic [15:0] mind);
    in_item_t p;
    p.coord_x = x;
    p.coord_y = y;
    p.first_point = first;
    p.last_point = last;
    p.next_is_start = nstart;
    p.min_distance = mind;
    p.line_width = 16'($urandom());
    return p;
  endfunction

  // polylines of modest coordinates around the center, with noise points when wild is set
  task automatic queue_polylines(int count, bit wild);
    int n, len;
    logic [31:0] x, y;
    n = 0;
    while (n < count) begin
      len = $urandom_range(8, 1);
      x = $urandom_range(4000) - 2000;
      y = $urandom_range(4000) - 2000;
      for (int k = 0; k < len; k++) begin
        if (wild && $urandom_range(9) == 0) begin
          x = $urandom();
          y = $urandom();
        end else begin
          x = x + $urandom_range(1200) - 600;
          y = y + $urandom_range(1200) - 600;
        end
        point_queue.push_back(make_point(x, y, k == 0 || $urandom_range(15) == 0,
                                         k == len - 1, $urandom_range(9) == 0,
                                         16'($urandom_range(3) == 0 ? $urandom() :
                                             $urandom_range(40))));
      end
      n += len;
    end
  endtask

  // random register setting: 2D or 3D with a near plane inside the z range
  task automatic random_setting(bit ddd);
    logic [63:0] s;
    write_reg(REG_MAP_CENTER, {32'($urandom_range(400) - 200), 32'($urandom_range(400) - 200)});
    write_reg(REG_MODE_SHIFT, 64'({ddd, 5'($urandom_range(3))}));
    write_reg(REG_ROT_ROW_X, {32'($urandom_range(64) - 32), 32'($urandom_range(64) - 32)});
    write_reg(REG_ROT_ROW_Y, {32'($urandom_range(64) - 32), 32'($urandom_range(64) - 32)});
    write_reg(REG_ROT_ROW_Z, {32'($urandom_range(16) - 8), 32'($urandom_range(16) - 8)});
    write_reg(REG_DEPTH_PARAMS, {32'($urandom_range(2000)), 32'($urandom_range(40000))});
    write_reg(REG_SCREEN_OFFSET, {32'($urandom_range(2000)), 32'($urandom_range(2000))});
    s = {$urandom(), $urandom()};
    write_reg(REG_PROJ_SCALES, s);
  endtask

  initial begin
    r_center = '0; r_rot_x = '0; r_rot_y = '0; r_rot_z = '0;
    r_depth = '0; r_offset = '0; r_mode = '0; r_scales = '0;
    hist_vis = VIS_UNKNOWN;
    hist_x = '0; hist_y = '0; hist_z = '0; shown_x = '0; shown_y = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes in 2D with extreme register values
    write_reg(REG_MAP_CENTER, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MODE_SHIFT, 64'h1F);
    write_reg(REG_ROT_ROW_X, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ROT_ROW_Y, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_ROT_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_DEPTH_PARAMS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SCREEN_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PROJ_SCALES, 64'h7FFF_FFFF_FFFF_FFFF);
    point_queue.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 16'hFFFF));
    point_queue.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 16'hFFFF));
    point_queue.push_back(make_point('0, '0, 0, 0, 1, 0));
    point_queue.push_back(make_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 16'hFFFF));
    drain();

    // directed 3D: crossings both ways, equal depths, zero depth, culling
    write_reg(REG_MAP_CENTER, '0);
    write_reg(REG_MODE_SHIFT, 64'h20);
    write_reg(REG_ROT_ROW_X, {32'd1, 32'd0});
    write_reg(REG_ROT_ROW_Y, {32'd0, 32'd1});
    write_reg(REG_ROT_ROW_Z, {32'd0, 32'd1});
    write_reg(REG_DEPTH_PARAMS, {32'd0, 32'd100});
    write_reg(REG_SCREEN_OFFSET, '0);
    write_reg(REG_PROJ_SCALES, 64'({21'd1000, 21'd1000, 21'h1FFFFF}));
    point_queue.push_back(make_point(10, 500, 1, 0, 0, 0));    // visible start
    point_queue.push_back(make_point(20, 50, 0, 0, 0, 3));     // goes behind plane
    point_queue.push_back(make_point(30, 40, 0, 0, 0, 3));     // stays hidden
    point_queue.push_back(make_point(40, 300, 0, 0, 0, 3));    // comes back
    point_queue.push_back(make_point(41, 301, 0, 0, 0, 60000)); // culled
    point_queue.push_back(make_point(5, 0, 1, 0, 0, 0));       // hidden, z zero
    point_queue.push_back(make_point(-5, 0, 0, 0, 0, 0));      // hidden, equal depth
    point_queue.push_back(make_point(7, 100, 0, 0, 1, 0));     // on the plane
    point_queue.push_back(make_point(9, -200, 0, 1, 0, 0));    // leaves, last point
    drain();
    write_reg(REG_DEPTH_PARAMS, {32'd0, 32'hFFFF_FFFF});
    drain();
    write_reg(REG_DEPTH_PARAMS, {32'd0, 32'd0});
    point_queue.push_back(make_point(3, 0, 1, 0, 0, 0));       // perspective by zero
    point_queue.push_back(make_point(3, -1, 0, 0, 0, 0));
    point_queue.push_back(make_point(3, 0, 0, 1, 0, 0));       // equal depth in a clip
    drain();

    // random phases, idling pattern changes each third
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 18 : (ph < 6) ? 49 : 0;
      recv_idle_pct = (ph < 3) ? 49 : (ph < 6) ? 18 : 0;
      random_setting(ph % 3 != 0);
      queue_polylines(ph % 3 == 0 ? 300 : 160, ph == 4);
      drain();
    end

    if (!any_error) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mpvt_pkg.sv
rtl/mpvt_div.sv
rtl/mpvt_datapath.sv
rtl/mpvt_ctrl.sv
rtl/map_point_view_transform.sv
tb/tb_map_point_view_transform.sv
